// ----- sv/wlfc_pkg.sv -----
package wlfc_pkg;

  // Field widths
  localparam int ELAPSED_W = 10;
  localparam int VOLTS_W   = 10;
  localparam int VACUUM_W  = 10;
  localparam int FUEL_W    = 12;
  localparam int OIL_W     = 12;
  localparam int FLASH_W   = 16;
  localparam int LAMP_N    = 6;

  // Stream widths, fields packed from bit 0 up, padded to whole bytes
  localparam int S_FIELDS_W = ELAPSED_W + VOLTS_W + 1 + 2 * VACUUM_W + 2 * FUEL_W + OIL_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((LAMP_N + 7) / 8) * 8;

  // Input field offsets within s_tdata
  localparam int OFS_ELAPSED   = 0;
  localparam int OFS_VOLTS     = OFS_ELAPSED + ELAPSED_W;
  localparam int OFS_POWER_OK  = OFS_VOLTS + VOLTS_W;
  localparam int OFS_VAC_LEFT  = OFS_POWER_OK + 1;
  localparam int OFS_VAC_RIGHT = OFS_VAC_LEFT + VACUUM_W;
  localparam int OFS_FUEL_LEFT = OFS_VAC_RIGHT + VACUUM_W;
  localparam int OFS_FUEL_RGT  = OFS_FUEL_LEFT + FUEL_W;
  localparam int OFS_OIL       = OFS_FUEL_RGT + FUEL_W;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = FLASH_W;

  localparam logic [CFG_INDEX_W-1:0] REG_POWER_MIN  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_VOLTS_LOW  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FUEL_LOW   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_VACUUM_LOW = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_OIL_LOW    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FLASH_TIME = 3'd5;

  // Register reset values
  localparam logic [VOLTS_W-1:0]  POWER_MIN_RST  = 10'd80;
  localparam logic [VOLTS_W-1:0]  VOLTS_LOW_RST  = 10'd392;
  localparam logic [FUEL_W-1:0]   FUEL_LOW_RST   = 12'd80;
  localparam logic [VACUUM_W-1:0] VACUUM_LOW_RST = 10'd48;
  localparam logic [OIL_W-1:0]    OIL_LOW_RST    = 12'd320;
  localparam logic [FLASH_W-1:0]  FLASH_TIME_RST = 16'd10240;

  // Output lamp bit positions within m_tdata
  localparam int LAMP_VOLTS      = 0;
  localparam int LAMP_VAC_LEFT   = 1;
  localparam int LAMP_VAC_RIGHT  = 2;
  localparam int LAMP_FUEL_LEFT  = 3;
  localparam int LAMP_FUEL_RIGHT = 4;
  localparam int LAMP_OIL        = 5;

  // Parameter defaults
  localparam int TIME_FRAC_BITS_DEF = 10;
  localparam int TIMER_WIDTH_DEF    = 16;

endpackage

// ----- sv/warning_lamp_flash_controller.sv -----
// Warning lamp flash controller.
// Slave stream (s_tvalid/s_tready/s_tdata): one request per tick carrying the
// elapsed time and the sensor readings. Master stream (m_tvalid/m_tready/
// m_tdata): one result per request with the six lamp states, in order.
// Config port (cfg_we/cfg_index/cfg_data): write thresholds and flash time
// while idle; indexes beyond the last register are ignored.
// A request lands in an input register; the lamp logic and timer update run
// as it moves on to the output register, where the result is held. A result
// passes through the input and output registers to m_tvalid, and m_tready low
// can hold it in the input register. Throughput is one request per cycle
// while m_tready stays high, set by the single pass of adds and compares
// between the two registers. Timers and phase update as each request moves
// to the output. Reset clears both registers' valid flags, the phase and
// alarm timers, and loads the default thresholds and flash time. When
// m_tready is low the result holds; one more request is taken into the input
// register, then s_tready drops until the output register is free.
module warning_lamp_flash_controller #(
  parameter int TIME_FRAC_BITS = wlfc_pkg::TIME_FRAC_BITS_DEF,
  parameter int TIMER_WIDTH    = wlfc_pkg::TIMER_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // elapsed, bus_voltage, power_ok, vacuum_left, vacuum_right, fuel_left,
  // fuel_right, oil_pressure, zero pad
  input  logic [wlfc_pkg::S_TDATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // lamp_volts, lamp_vacuum_left, lamp_vacuum_right, lamp_fuel_left,
  // lamp_fuel_right, lamp_oil, zero pad
  output logic [wlfc_pkg::M_TDATA_W-1:0]    m_tdata,
  input  logic                              cfg_we,
  input  logic [wlfc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [wlfc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import wlfc_pkg::*;

  localparam int PH_ADD_W = (TIME_FRAC_BITS > ELAPSED_W) ? TIME_FRAC_BITS : ELAPSED_W;
  localparam int SUM_W    = ((TIMER_WIDTH > ELAPSED_W) ? TIMER_WIDTH : ELAPSED_W) + 1;
  localparam int CMP_W    = (TIMER_WIDTH > FLASH_W) ? TIMER_WIDTH : FLASH_W;
  localparam logic [TIME_FRAC_BITS-1:0] PHASE_HALF =
    TIME_FRAC_BITS'(1) << (TIME_FRAC_BITS - 1);
  localparam logic [SUM_W-1:0] TIMER_TOP = SUM_W'({TIMER_WIDTH{1'b1}});

  // Configuration registers
  logic [VOLTS_W-1:0]  power_min;
  logic [VOLTS_W-1:0]  volts_low;
  logic [FUEL_W-1:0]   fuel_low;
  logic [VACUUM_W-1:0] vacuum_low;
  logic [OIL_W-1:0]    oil_low;
  logic [FLASH_W-1:0]  flash_time;

  // Input register
  logic                 in_valid;
  logic [ELAPSED_W-1:0] in_elapsed;
  logic [VOLTS_W-1:0]   in_volts;
  logic                 in_power_ok;
  logic [VACUUM_W-1:0]  in_vac_left;
  logic [VACUUM_W-1:0]  in_vac_right;
  logic [FUEL_W-1:0]    in_fuel_left;
  logic [FUEL_W-1:0]    in_fuel_right;
  logic [OIL_W-1:0]     in_oil;

  // State
  logic [TIME_FRAC_BITS-1:0] phase;
  logic [TIMER_WIDTH-1:0]    volts_time;
  logic [TIMER_WIDTH-1:0]    fuel_time;
  logic [TIMER_WIDTH-1:0]    vacuum_time;
  logic [TIMER_WIDTH-1:0]    oil_time;

  // Output register
  logic              out_valid;
  logic [LAMP_N-1:0] lamps;

  logic                      advance;
  logic [PH_ADD_W-1:0]       phase_sum;
  logic [TIME_FRAC_BITS-1:0] phase_next;
  logic [TIMER_WIDTH-1:0]    volts_time_adv, fuel_time_adv, vacuum_time_adv, oil_time_adv;
  logic [TIMER_WIDTH-1:0]    volts_time_next, fuel_time_next;
  logic [TIMER_WIDTH-1:0]    vacuum_time_next, oil_time_next;
  logic                      power_off, blink;
  logic                      a_volts, a_vl, a_vr, a_fl, a_fr, a_oil;
  logic [LAMP_N-1:0]         lamps_next;

  function automatic logic [TIMER_WIDTH-1:0] sat_add(input logic [TIMER_WIDTH-1:0] t,
                                                     input logic [ELAPSED_W-1:0] d);
    logic [SUM_W-1:0] s;
    s = SUM_W'(t) + SUM_W'(d);
    return (s > TIMER_TOP) ? {TIMER_WIDTH{1'b1}} : TIMER_WIDTH'(s);
  endfunction

  function automatic logic lamp_on(input logic alarm, input logic [TIMER_WIDTH-1:0] t,
                                   input logic [FLASH_W-1:0] ft, input logic lit);
    return alarm && ((CMP_W'(t) >= CMP_W'(ft)) || lit);
  endfunction

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = M_TDATA_W'(lamps);

  always_comb begin
    phase_sum  = PH_ADD_W'(phase) + PH_ADD_W'(in_elapsed);
    phase_next = phase_sum[TIME_FRAC_BITS-1:0];
    blink      = phase_next <= PHASE_HALF;

    volts_time_adv  = sat_add(volts_time, in_elapsed);
    fuel_time_adv   = sat_add(fuel_time, in_elapsed);
    vacuum_time_adv = sat_add(vacuum_time, in_elapsed);
    oil_time_adv    = sat_add(oil_time, in_elapsed);

    power_off = (in_volts < power_min) || !in_power_ok;
    a_volts   = in_volts < volts_low;
    a_vl      = in_vac_left < vacuum_low;
    a_vr      = in_vac_right < vacuum_low;
    a_fl      = in_fuel_left < fuel_low;
    a_fr      = in_fuel_right < fuel_low;
    a_oil     = in_oil < oil_low;

    lamps_next = '0;
    volts_time_next  = volts_time_adv;
    fuel_time_next   = fuel_time_adv;
    vacuum_time_next = vacuum_time_adv;
    oil_time_next    = oil_time_adv;
    if (!power_off) begin
      lamps_next[LAMP_VOLTS]      = lamp_on(a_volts, volts_time_adv, flash_time, blink);
      lamps_next[LAMP_VAC_LEFT]   = lamp_on(a_vl, vacuum_time_adv, flash_time, blink);
      lamps_next[LAMP_VAC_RIGHT]  = lamp_on(a_vr, vacuum_time_adv, flash_time, blink);
      lamps_next[LAMP_FUEL_LEFT]  = lamp_on(a_fl, fuel_time_adv, flash_time, blink);
      lamps_next[LAMP_FUEL_RIGHT] = lamp_on(a_fr, fuel_time_adv, flash_time, blink);
      lamps_next[LAMP_OIL]        = lamp_on(a_oil, oil_time_adv, flash_time, blink);
      // clear a group's timer once none of its readings alarm
      if (!a_volts)      volts_time_next  = '0;
      if (!a_fl && !a_fr) fuel_time_next   = '0;
      if (!a_vl && !a_vr) vacuum_time_next = '0;
      if (!a_oil)        oil_time_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_min  <= POWER_MIN_RST;
      volts_low  <= VOLTS_LOW_RST;
      fuel_low   <= FUEL_LOW_RST;
      vacuum_low <= VACUUM_LOW_RST;
      oil_low    <= OIL_LOW_RST;
      flash_time <= FLASH_TIME_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POWER_MIN:  power_min  <= cfg_data[VOLTS_W-1:0];
        REG_VOLTS_LOW:  volts_low  <= cfg_data[VOLTS_W-1:0];
        REG_FUEL_LOW:   fuel_low   <= cfg_data[FUEL_W-1:0];
        REG_VACUUM_LOW: vacuum_low <= cfg_data[VACUUM_W-1:0];
        REG_OIL_LOW:    oil_low    <= cfg_data[OIL_W-1:0];
        REG_FLASH_TIME: flash_time <= cfg_data[FLASH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_elapsed    <= s_tdata[OFS_ELAPSED +: ELAPSED_W];
      in_volts      <= s_tdata[OFS_VOLTS +: VOLTS_W];
      in_power_ok   <= s_tdata[OFS_POWER_OK];
      in_vac_left   <= s_tdata[OFS_VAC_LEFT +: VACUUM_W];
      in_vac_right  <= s_tdata[OFS_VAC_RIGHT +: VACUUM_W];
      in_fuel_left  <= s_tdata[OFS_FUEL_LEFT +: FUEL_W];
      in_fuel_right <= s_tdata[OFS_FUEL_RGT +: FUEL_W];
      in_oil        <= s_tdata[OFS_OIL +: OIL_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      phase       <= '0;
      volts_time  <= '0;
      fuel_time   <= '0;
      vacuum_time <= '0;
      oil_time    <= '0;
    end else begin
      if (advance) begin
        out_valid   <= 1'b1;
        phase       <= phase_next;
        volts_time  <= volts_time_next;
        fuel_time   <= fuel_time_next;
        vacuum_time <= vacuum_time_next;
        oil_time    <= oil_time_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lamps <= lamps_next;
    end
  end

`ifndef SYNTHESIS
  a_dark_when_unpowered: assert property (@(posedge clk) disable iff (rst)
    advance && power_off |=> lamps == '0)
    else $error("lamps lit while bus unpowered");

  a_volts_timer_cleared: assert property (@(posedge clk) disable iff (rst)
    advance && !power_off && !a_volts |=> volts_time == '0)
    else $error("volts timer not cleared after alarm dropped");

  a_steady_after_flash: assert property (@(posedge clk) disable iff (rst)
    advance && !power_off && a_oil && (CMP_W'(oil_time_adv) >= CMP_W'(flash_time))
    |=> lamps[LAMP_OIL])
    else $error("oil lamp not steady after flash time");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(phase) && $stable(fuel_time) && $stable(vacuum_time))
    else $error("state changed without an item moving to the output");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> s_tready)
    else $error("input stalled with output register empty");
`endif

endmodule
